/* hw/rtl/lwps_pkg.sv */
// Shared types and constants for the LCD window/pixel byte streamer.
// No dependencies; imported by every module of the block.
package lwps_pkg;

  // Input request codes
  localparam logic [1:0] FUNC_WINDOW = 2'd0;
  localparam logic [1:0] FUNC_PIXEL  = 2'd1;
  localparam logic [1:0] FUNC_RAW    = 2'd2;
  localparam logic [1:0] FUNC_END    = 2'd3;

  // Result kinds
  localparam logic [1:0] KIND_BYTE    = 2'd0;
  localparam logic [1:0] KIND_RELEASE = 2'd1;
  localparam logic [1:0] KIND_ERROR   = 2'd2;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_ROTATION    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PANEL_READY = 1'd1;
  localparam logic [1:0] ROTATION_RESET = 2'd2;

  // Controller commands
  localparam logic [7:0] CMD_CASET = 8'h2A;
  localparam logic [7:0] CMD_RASET = 8'h2B;
  localparam logic [7:0] CMD_RAMWR = 8'h2C;

  // Panel offsets
  localparam logic [5:0] OFS_40 = 6'd40;
  localparam logic [5:0] OFS_52 = 6'd52;
  localparam logic [5:0] OFS_53 = 6'd53;

  // Coordinate widths
  localparam int unsigned COORD_W = 9;
  localparam int unsigned CORNER_W = 10;

  // Byte positions within a window sequence
  localparam int unsigned IDX_W = 4;
  localparam logic [IDX_W-1:0] IDX_CASET  = 4'd0;
  localparam logic [IDX_W-1:0] IDX_XS_HI  = 4'd1;
  localparam logic [IDX_W-1:0] IDX_XS_LO  = 4'd2;
  localparam logic [IDX_W-1:0] IDX_XE_HI  = 4'd3;
  localparam logic [IDX_W-1:0] IDX_XE_LO  = 4'd4;
  localparam logic [IDX_W-1:0] IDX_RASET  = 4'd5;
  localparam logic [IDX_W-1:0] IDX_YS_HI  = 4'd6;
  localparam logic [IDX_W-1:0] IDX_YS_LO  = 4'd7;
  localparam logic [IDX_W-1:0] IDX_YE_HI  = 4'd8;
  localparam logic [IDX_W-1:0] IDX_YE_LO  = 4'd9;
  localparam logic [IDX_W-1:0] IDX_RAMWR  = 4'd10;
  localparam logic [IDX_W-1:0] IDX_PIX_LO = 4'd1;

  // Command queue depth
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // Classified operation handed from front to back
  typedef enum logic [2:0] {
    OP_WIN,
    OP_PIX,
    OP_RAW,
    OP_END,
    OP_ERR
  } op_t;

  typedef struct packed {
    op_t                 op;
    logic [CORNER_W-1:0] xs;
    logic [CORNER_W-1:0] xe;
    logic [CORNER_W-1:0] ys;
    logic [CORNER_W-1:0] ye;
    logic [15:0]         data;
    logic                hold;
    logic                burst_last;
  } entry_t;

  typedef struct packed {
    logic [5:0] cx;
    logic [5:0] cy;
  } offset_t;

  // Panel offsets per orientation
  function automatic offset_t rot_offset(input logic [1:0] rot);
    offset_t o;
    case (rot)
      2'd0:    begin o.cx = OFS_52; o.cy = OFS_40; end
      2'd1:    begin o.cx = OFS_53; o.cy = OFS_40; end
      2'd2:    begin o.cx = OFS_40; o.cy = OFS_53; end
      default: begin o.cx = OFS_40; o.cy = OFS_52; end
    endcase
    return o;
  endfunction

endpackage

/* hw/rtl/lwps_front.sv */
// Front end: configuration registers, request classification and window offsets.
// Tracks the select-held state in request order. Depends on lwps_pkg.
module lwps_front import lwps_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            in_func,
  input  logic [COORD_W-1:0]    in_x_start,
  input  logic [COORD_W-1:0]    in_y_start,
  input  logic [COORD_W-1:0]    in_x_end,
  input  logic [COORD_W-1:0]    in_y_end,
  input  logic [15:0]           in_data_value,
  input  logic                  in_burst_last,
  output logic                  push_valid,
  input  logic                  push_ready,
  output entry_t                push_entry
);

  logic [1:0] rotation_r;
  logic       panel_ready_r;
  logic       select_held_r, select_held_nxt;
  logic       accept;
  offset_t    ofs;

  assign in_ready   = push_ready;
  assign push_valid = in_valid;
  assign accept     = in_valid & push_ready;
  assign ofs        = rot_offset(rotation_r);

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rotation_r    <= ROTATION_RESET;
      panel_ready_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ROTATION:    rotation_r    <= cfg_data[1:0];
        CFG_PANEL_READY: panel_ready_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Classify the request and offset its corners
  always_comb begin
    push_entry.xs         = CORNER_W'(in_x_start) + CORNER_W'(ofs.cx);
    push_entry.xe         = CORNER_W'(in_x_end)   + CORNER_W'(ofs.cx);
    push_entry.ys         = CORNER_W'(in_y_start) + CORNER_W'(ofs.cy);
    push_entry.ye         = CORNER_W'(in_y_end)   + CORNER_W'(ofs.cy);
    push_entry.data       = in_data_value;
    push_entry.hold       = select_held_r;
    push_entry.burst_last = in_burst_last;
    select_held_nxt       = select_held_r;
    if (in_func == FUNC_END) begin
      push_entry.op   = OP_END;
      select_held_nxt = 1'b0;
    end else if (!panel_ready_r) begin
      push_entry.op = OP_ERR;
    end else begin
      unique case (in_func)
        FUNC_WINDOW: begin
          push_entry.op   = OP_WIN;
          select_held_nxt = 1'b1;
        end
        FUNC_PIXEL: push_entry.op = OP_PIX;
        default:    push_entry.op = OP_RAW;
      endcase
    end
  end

  // Advance select state on each accepted transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      select_held_r <= 1'b0;
    end else if (accept) begin
      select_held_r <= select_held_nxt;
    end
  end

endmodule

/* hw/rtl/lwps_queue.sv */
// Short command queue between front and back ends.
// Register-based ring buffer of entry_t; depends on lwps_pkg.
module lwps_queue import lwps_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push_valid,
  output logic   push_ready,
  input  entry_t push_entry,
  output logic   pop_valid,
  input  logic   pop_ready,
  output entry_t pop_entry
);

  entry_t            mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic              do_push, do_pop;

  assign push_ready = (count_r != QCNT_W'(QDEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_entry  = mem_r[rd_ptr_r];
  assign do_push    = push_valid & push_ready;
  assign do_pop     = pop_valid & pop_ready;

  // Store pushed entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

/* hw/rtl/lwps_back.sv */
// Back end: expands queued operations into one result per cycle while out_ready does not stall it.
// Byte sequencer feeding a registered output stage; depends on lwps_pkg.
module lwps_back import lwps_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        pop_valid,
  output logic        pop_ready,
  input  entry_t      pop_entry,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_byte_out,
  output logic        out_is_data,
  output logic        out_hold_select,
  output logic        out_last,
  output logic        out_burst_done
);

  logic [IDX_W-1:0] idx_r;
  logic             out_valid_r;
  logic [1:0]       kind_r, kind_nxt;
  logic [7:0]       byte_r, byte_nxt;
  logic             is_data_r, is_data_nxt;
  logic             hold_r, hold_nxt;
  logic             last_r, last_nxt;
  logic             burst_r;
  logic             advance, emit;

  assign advance   = !out_valid_r || out_ready;
  assign emit      = advance && pop_valid;
  assign pop_ready = advance && last_nxt;

  // Select the byte at the current position of the head operation
  always_comb begin
    kind_nxt    = KIND_BYTE;
    byte_nxt    = '0;
    is_data_nxt = 1'b1;
    hold_nxt    = pop_entry.hold;
    last_nxt    = 1'b1;
    case (pop_entry.op)
      OP_WIN: begin
        hold_nxt = 1'b0;
        last_nxt = (idx_r == IDX_RAMWR);
        case (idx_r)
          IDX_CASET: begin byte_nxt = CMD_CASET; is_data_nxt = 1'b0; end
          IDX_XS_HI: byte_nxt = 8'(pop_entry.xs[CORNER_W-1:8]);
          IDX_XS_LO: byte_nxt = pop_entry.xs[7:0];
          IDX_XE_HI: byte_nxt = 8'(pop_entry.xe[CORNER_W-1:8]);
          IDX_XE_LO: byte_nxt = pop_entry.xe[7:0];
          IDX_RASET: begin byte_nxt = CMD_RASET; is_data_nxt = 1'b0; end
          IDX_YS_HI: byte_nxt = 8'(pop_entry.ys[CORNER_W-1:8]);
          IDX_YS_LO: byte_nxt = pop_entry.ys[7:0];
          IDX_YE_HI: byte_nxt = 8'(pop_entry.ye[CORNER_W-1:8]);
          IDX_YE_LO: byte_nxt = pop_entry.ye[7:0];
          default: begin
            byte_nxt    = CMD_RAMWR;
            is_data_nxt = 1'b0;
            hold_nxt    = 1'b1;
          end
        endcase
      end
      OP_PIX: begin
        last_nxt = (idx_r == IDX_PIX_LO);
        byte_nxt = (idx_r == IDX_PIX_LO) ? pop_entry.data[7:0] : pop_entry.data[15:8];
      end
      OP_RAW: byte_nxt = pop_entry.data[7:0];
      OP_END: begin
        kind_nxt    = KIND_RELEASE;
        is_data_nxt = 1'b0;
        hold_nxt    = 1'b0;
      end
      default: begin
        kind_nxt    = KIND_ERROR;
        is_data_nxt = 1'b0;
        hold_nxt    = 1'b0;
      end
    endcase
  end

  // Step through the head operation
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= pop_valid;
      if (emit) begin
        idx_r <= last_nxt ? '0 : idx_r + 1'b1;
      end
    end
  end

  // Load the output register
  always_ff @(posedge clk) begin
    if (emit) begin
      kind_r    <= kind_nxt;
      byte_r    <= byte_nxt;
      is_data_r <= is_data_nxt;
      hold_r    <= hold_nxt;
      last_r    <= last_nxt;
      burst_r   <= last_nxt & pop_entry.burst_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = kind_r;
  assign out_byte_out    = byte_r;
  assign out_is_data     = is_data_r;
  assign out_hold_select = hold_r;
  assign out_last        = last_r;
  assign out_burst_done  = burst_r;

endmodule

/* hw/rtl/lcd_window_pixel_byte_streamer.sv */
// LCD window/pixel byte streamer: top level joining front end, queue and back end.
// Path: an accepted request is written into the queue, then loaded into the output register.
// Throughput: one result per cycle while out_ready does not stall it, set by the back-end byte sequencer;
// a window yields 11 results, a pixel 2, a raw byte, end or error 1; a 2-entry queue decouples the input.
// Reset: synchronous active-low; rotation 2, panel not ready, select released, queue empty.
// Depends on lwps_pkg, lwps_front, lwps_queue, lwps_back.
module lcd_window_pixel_byte_streamer import lwps_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            in_func,
  input  logic [COORD_W-1:0]    in_x_start,
  input  logic [COORD_W-1:0]    in_y_start,
  input  logic [COORD_W-1:0]    in_x_end,
  input  logic [COORD_W-1:0]    in_y_end,
  input  logic [15:0]           in_data_value,
  input  logic                  in_burst_last,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            out_kind,
  output logic [7:0]            out_byte_out,
  output logic                  out_is_data,
  output logic                  out_hold_select,
  output logic                  out_last,
  output logic                  out_burst_done
);

  logic   push_valid, push_ready, pop_valid, pop_ready;
  entry_t push_entry, pop_entry;

  // Accept and classify requests
  lwps_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_func       (in_func),
    .in_x_start    (in_x_start),
    .in_y_start    (in_y_start),
    .in_x_end      (in_x_end),
    .in_y_end      (in_y_end),
    .in_data_value (in_data_value),
    .in_burst_last (in_burst_last),
    .push_valid    (push_valid),
    .push_ready    (push_ready),
    .push_entry    (push_entry)
  );

  // Buffer classified operations
  lwps_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_entry  (pop_entry)
  );

  // Expand operations into result transactions
  lwps_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .pop_valid       (pop_valid),
    .pop_ready       (pop_ready),
    .pop_entry       (pop_entry),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_kind        (out_kind),
    .out_byte_out    (out_byte_out),
    .out_is_data     (out_is_data),
    .out_hold_select (out_hold_select),
    .out_last        (out_last),
    .out_burst_done  (out_burst_done)
  );

`ifndef ASSERT_OFF
  // Release and error results stand alone
  a_single_nonbyte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_BYTE |-> out_last && out_byte_out == 8'h00)
    else $error("non-byte result not a lone last result");

  // Only the memory-write command keeps select held among command bytes
  a_hold_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_BYTE && !out_is_data && out_hold_select
    |-> out_byte_out == CMD_RAMWR && out_last)
    else $error("held command byte is not the closing memory write");

  // Burst flag appears only on an item's final result
  a_burst_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_burst_done |-> out_last)
    else $error("burst_done on a non-final result");
`endif

endmodule
